// ===== rtl/huffman_table_bit_decoder_core_assert.svh =====
// Assertion macros for the Huffman table decoder checker.
// Used by hbd_checker only; expects i_clk and i_rst_n in scope.
`ifndef HUFFMAN_TABLE_BIT_DECODER_CORE_ASSERT_SVH
`define HUFFMAN_TABLE_BIT_DECODER_CORE_ASSERT_SVH

// same-cycle implication, masked during reset
`define HBD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hbd assertion failed");

// next-cycle implication, masked during reset
`define HBD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hbd assertion failed");

// next-cycle implication that also runs across reset
`define HBD_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("hbd reset assertion failed");

`endif

// ===== rtl/hbd_pkg.sv =====
// Shared types and constants for the Huffman table decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hbd_pkg;

    localparam int NODE_TABLE_DEPTH_DEF = 255;
    localparam int COUNT_WIDTH_DEF      = 32;
    localparam int BIT_TOP              = 7;
    localparam int CMD_QUEUE_DEPTH      = 4;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_DATA  = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_START,
        OP_DATA
    } t_op;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  node_index;
        logic        left_is_node;
        logic [7:0]  left_value;
        logic        right_is_node;
        logic [7:0]  right_value;
        logic [7:0]  root_node;
        logic [31:0] total_symbols;
        logic [7:0]  data_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_of_byte;
        logic       message_done;
    } t_out_word;

    typedef struct packed {
        logic       left_is_node;
        logic [7:0] left_value;
        logic       right_is_node;
        logic [7:0] right_value;
    } t_node;

    // one classified command as held in the queue
    typedef struct packed {
        t_op         op;
        logic [7:0]  index;
        t_node       node;
        logic [7:0]  root;
        logic [31:0] count;
        logic [7:0]  data_byte;
    } t_cmd;

endpackage

// ===== rtl/hbd_front.sv =====
// Front end: accepts input words, classifies them and queues commands.
// Depends on hbd_pkg.
`timescale 1ns / 1ps

module hbd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  hbd_pkg::t_in_word i_data,
    output logic            o_cmd_valid,
    output hbd_pkg::t_cmd   o_cmd,
    input  logic            i_cmd_pop
);
    import hbd_pkg::*;

    localparam int PW = $clog2(CMD_QUEUE_DEPTH);
    localparam int CNTW = $clog2(CMD_QUEUE_DEPTH + 1);

    t_cmd            r_q [CMD_QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0] r_count, n_count;

    logic  push;
    logic  known;
    t_cmd  cmd;

    always_comb begin
        known  = 1'b1;
        cmd.op = OP_DATA;
        unique case (i_data.func)
            FUNC_LOAD:  cmd.op = OP_LOAD;
            FUNC_START: cmd.op = OP_START;
            FUNC_DATA:  cmd.op = OP_DATA;
            default:    known  = 1'b0;   // unused code, word is dropped
        endcase
        cmd.index              = i_data.node_index;
        cmd.node.left_is_node  = i_data.left_is_node;
        cmd.node.left_value    = i_data.left_value;
        cmd.node.right_is_node = i_data.right_is_node;
        cmd.node.right_value   = i_data.right_value;
        cmd.root               = i_data.root_node;
        cmd.count              = i_data.total_symbols;
        cmd.data_byte          = i_data.data_byte;
    end

    assign o_ready     = (r_count != CNTW'(CMD_QUEUE_DEPTH));
    assign push        = i_valid && o_ready && known;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + PW'(1) : r_wr_ptr;
        n_rd_ptr = i_cmd_pop ? r_rd_ptr + PW'(1) : r_rd_ptr;
        n_count  = r_count + CNTW'(push) - CNTW'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

endmodule

// ===== rtl/hbd_back.sv =====
// Back end: node table memory, bit-serial tree walk and output register.
// Depends on hbd_pkg; fed by hbd_front.
`timescale 1ns / 1ps

module hbd_back #(
    parameter int NODE_TABLE_DEPTH = hbd_pkg::NODE_TABLE_DEPTH_DEF,
    parameter int COUNT_WIDTH      = hbd_pkg::COUNT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  hbd_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output hbd_pkg::t_out_word o_data
);
    import hbd_pkg::*;

    localparam int AW = (NODE_TABLE_DEPTH > 1) ? $clog2(NODE_TABLE_DEPTH) : 1;
    localparam int BCW = $clog2(BIT_TOP + 1);

    t_node r_table [NODE_TABLE_DEPTH];
    t_node r_rd_node;
    logic  r_rd_oob;

    logic                   r_busy, n_busy;
    logic [7:0]             r_byte, n_byte;
    logic [BCW-1:0]         r_bit, n_bit;
    logic [7:0]             r_walk, n_walk;
    logic [7:0]             r_root, n_root;
    logic [COUNT_WIDTH-1:0] r_left, n_left;
    logic                   r_finished, n_finished;

    // symbol held back until we know whether it ends its byte
    logic       r_pend_valid, n_pend_valid;
    logic       r_pend_final, n_pend_final;
    logic       r_pend_done, n_pend_done;
    logic [7:0] r_pend_sym, n_pend_sym;

    logic       r_out_valid;
    t_out_word  r_out_data;

    t_node                  entry;
    logic                   child_is_node;
    logic [7:0]             child_val;
    logic                   leaf, out_space, step, hit_zero, last_step, push;
    logic [COUNT_WIDTH-1:0] dec_left, start_cnt;
    logic                   s_finished, s_busy;
    logic                   we;

    always_comb begin
        entry         = r_rd_oob ? '0 : r_rd_node;
        child_is_node = r_byte[BIT_TOP] ? entry.right_is_node : entry.left_is_node;
        child_val     = r_byte[BIT_TOP] ? entry.right_value : entry.left_value;
        leaf          = r_busy && !child_is_node;
        out_space     = !r_out_valid || i_ready;
        step          = r_busy && (!leaf || !r_pend_valid || out_space);
        dec_left      = r_left - COUNT_WIDTH'(1);
        hit_zero      = leaf && (dec_left == '0);
        last_step     = step && ((r_bit == '0) || hit_zero);
        push          = r_pend_valid && out_space && (r_pend_final || (step && leaf));
        s_finished    = r_finished || (step && hit_zero);
        s_busy        = r_busy && !last_step;
        start_cnt     = COUNT_WIDTH'(i_cmd.count);
    end

    assign o_cmd_pop = i_cmd_valid && !s_busy;

    always_comb begin
        n_walk     = r_walk;
        n_left     = r_left;
        n_byte     = r_byte;
        n_bit      = r_bit;
        n_root     = r_root;
        n_finished = s_finished;
        n_busy     = s_busy;
        we         = 1'b0;
        if (step) begin
            n_walk = leaf ? r_root : child_val;
            n_byte = {r_byte[6:0], 1'b0};
            n_bit  = r_bit - BCW'(1);
            if (leaf) begin
                n_left = dec_left;
            end
        end
        if (o_cmd_pop) begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    we = ({1'b0, i_cmd.index} < 9'(NODE_TABLE_DEPTH));
                end
                OP_START: begin
                    n_root     = i_cmd.root;
                    n_walk     = i_cmd.root;
                    n_left     = start_cnt;
                    n_finished = (start_cnt == '0);
                end
                OP_DATA: begin
                    if (!s_finished) begin
                        n_busy = 1'b1;
                        n_byte = i_cmd.data_byte;
                        n_bit  = BCW'(BIT_TOP);
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_final = r_pend_final;
        n_pend_done  = r_pend_done;
        n_pend_sym   = r_pend_sym;
        if (step && leaf) begin
            n_pend_valid = 1'b1;
            n_pend_sym   = child_val;
            n_pend_done  = hit_zero;
            n_pend_final = (r_bit == '0) || hit_zero;
        end else if (push) begin
            n_pend_valid = 1'b0;
        end else if (step && (r_bit == '0)) begin
            n_pend_final = 1'b1;    // byte ended on an internal node
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_walk       <= '0;
            r_root       <= '0;
            r_left       <= '0;
            r_finished   <= 1'b1;
            r_bit        <= '0;
            r_pend_valid <= 1'b0;
            r_pend_final <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_busy       <= n_busy;
            r_walk       <= n_walk;
            r_root       <= n_root;
            r_left       <= n_left;
            r_finished   <= n_finished;
            r_bit        <= n_bit;
            r_pend_valid <= n_pend_valid;
            r_pend_final <= n_pend_final;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte      <= n_byte;
        r_pend_done <= n_pend_done;
        r_pend_sym  <= n_pend_sym;
        if (push) begin
            r_out_data.symbol       <= r_pend_sym;
            r_out_data.last_of_byte <= r_pend_final;
            r_out_data.message_done <= r_pend_done;
        end
    end

    // table read follows the next walk node, so its entry is ready for the next bit
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_table[i_cmd.index[AW-1:0]] <= i_cmd.node;
        end
        if (we && (i_cmd.index == n_walk)) begin
            r_rd_node <= i_cmd.node;
        end else begin
            r_rd_node <= r_table[n_walk[AW-1:0]];
        end
        r_rd_oob <= ({1'b0, n_walk} >= 9'(NODE_TABLE_DEPTH));
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

// ===== rtl/huffman_table_bit_decoder_core.sv =====
// Huffman table-walk decoder: accepts node loads, message starts and data bytes, and
// walks each data byte MSB first through a node table held in a synchronous memory,
// one bit per clock while the output does not stall the walk; each bit depends on the
// table lookup of the bit before (the next node's entry is read in the cycle its number
// is known). Load and start words do not occupy the walk engine. A four-deep command
// queue sits between the input and the walk engine, so input is taken while a byte is
// being walked or a symbol waits on the output. Each symbol is held inside the engine
// until it is known whether it ends its byte, then leaves through a registered
// output; a stalled output pauses the walk only when a further symbol must be emitted.
// The node table needs no clearing after reset: entries must be loaded before use.
// Depends on hbd_pkg, hbd_front and hbd_back.
`timescale 1ns / 1ps

module huffman_table_bit_decoder_core #(
    parameter int NODE_TABLE_DEPTH = hbd_pkg::NODE_TABLE_DEPTH_DEF,
    parameter int COUNT_WIDTH      = hbd_pkg::COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  hbd_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output hbd_pkg::t_out_word o_data
);
    import hbd_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    hbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    hbd_back #(
        .NODE_TABLE_DEPTH (NODE_TABLE_DEPTH),
        .COUNT_WIDTH      (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

// ===== rtl/hbd_checker.sv =====
// Port-level checker for huffman_table_bit_decoder_core, bound to the top level.
// Depends on hbd_pkg and huffman_table_bit_decoder_core_assert.svh.
`timescale 1ns / 1ps
`include "huffman_table_bit_decoder_core_assert.svh"

module hbd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input hbd_pkg::t_out_word o_data
);
    import hbd_pkg::*;

    `HBD_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid)
    `HBD_ASSERT_NXT(a_out_stable, o_valid && !i_ready, $stable(o_data))
    // the symbol that ends a message also ends what its byte produces
    `HBD_ASSERT_IMP(a_done_is_last, o_valid && o_data.message_done, o_data.last_of_byte)
    // queue empty and output clear right after reset
    `HBD_ASSERT_RST(a_reset_state, !i_rst_n, o_ready && !o_valid)

endmodule

bind huffman_table_bit_decoder_core hbd_checker u_hbd_checker (.*);
